[hw/rtl/assert_macros.svh]
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// fixed-delay implication, disabled in reset
`define ASSERT_DELAY(label, clk, rst_n, a, n, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("delayed check failed");

`endif

[hw/rtl/ssp_pkg.sv]
package ssp_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_CAMERA_X      = 3'd2,
        CFG_CAMERA_Y      = 3'd3,
        CFG_DIR_X         = 3'd4,
        CFG_DIR_Y         = 3'd5,
        CFG_PLANE_X       = 3'd6,
        CFG_PLANE_Y       = 3'd7
    } cfg_index_t;

    localparam int SCR_W   = 13;
    localparam int POS_W   = 24;
    localparam int VEC_W   = 18;
    localparam int OFS_W   = 25;
    localparam int PROD_W  = 43;
    localparam int NUM_W   = 44;
    localparam int DPROD_W = 36;
    localparam int DET_W   = 37;
    localparam int SUM_W   = 45;
    localparam int CPROD_W = 57;

    // divider geometry
    localparam int DIV1_NW = 60;
    localparam int DIV1_DW = 37;
    localparam int DIV2_DW = 44;
    localparam int DIV3_NW = 29;
    localparam int DIV3_DW = 32;

endpackage

[hw/rtl/sprite_screen_projection_core.sv]
// throughput: one sprite per cycle; the two long divider pipelines in series (60 and 29
// stages, one quotient bit per stage) set the latency
// reset: rst_n clears all valid bits and loads the default camera and screen
// registers; the receiver cannot stall, busy stays low
module sprite_screen_projection_core
    import ssp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [POS_W-1:0]   sprite_x,
    input  logic [POS_W-1:0]   sprite_y,
    input  logic               last_sprite,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [POS_W-1:0]   cfg_data,
    output logic               done,
    output logic signed [31:0] depth,
    output logic signed [20:0] center_column,
    output logic [15:0]        sprite_size,
    output logic [19:0]        start_column,
    output logic signed [20:0] end_column,
    output logic [11:0]        start_row,
    output logic [11:0]        end_row,
    output logic               degenerate,
    output logic               last_out
);

`include "assert_macros.svh"

    localparam int LATENCY = 99;

    // configuration registers
    logic [SCR_W-1:0]        scr_w_reg, scr_h_reg;
    logic [POS_W-1:0]        cam_x_reg, cam_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg   <= 13'd640;
            scr_h_reg   <= 13'd480;
            cam_x_reg   <= '0;
            cam_y_reg   <= '0;
            dir_x_reg   <= -18'sd65536;
            dir_y_reg   <= '0;
            plane_x_reg <= '0;
            plane_y_reg <= 18'sd43254;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SCREEN_WIDTH:  scr_w_reg   <= cfg_data[SCR_W-1:0];
                CFG_SCREEN_HEIGHT: scr_h_reg   <= cfg_data[SCR_W-1:0];
                CFG_CAMERA_X:      cam_x_reg   <= cfg_data;
                CFG_CAMERA_Y:      cam_y_reg   <= cfg_data;
                CFG_DIR_X:         dir_x_reg   <= $signed(cfg_data[VEC_W-1:0]);
                CFG_DIR_Y:         dir_y_reg   <= $signed(cfg_data[VEC_W-1:0]);
                CFG_PLANE_X:       plane_x_reg <= $signed(cfg_data[VEC_W-1:0]);
                CFG_PLANE_Y:       plane_y_reg <= $signed(cfg_data[VEC_W-1:0]);
                default:           ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid and marker bits through the front stages
    logic       v_reg [1:6];
    logic       l_reg [1:6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 6; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[1] <= start & ~busy;
            for (int i = 2; i <= 6; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg[1] <= last_sprite;
        for (int i = 2; i <= 6; i++)
        begin
            l_reg[i] <= l_reg[i-1];
        end
    end

    // stage 1: offsets from the camera
    logic signed [OFS_W-1:0] sx_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        sx_reg <= $signed({1'b0, sprite_x}) - $signed({1'b0, cam_x_reg});
        sy_reg <= $signed({1'b0, sprite_y}) - $signed({1'b0, cam_y_reg});
    end

    // stage 2: products of the inverse camera matrix
    logic signed [PROD_W-1:0]  p_dysx_reg, p_dxsy_reg, p_pxsy_reg, p_pysx_reg;
    logic signed [DPROD_W-1:0] p_pxdy_reg, p_dxpy_reg;

    always_ff @(posedge clk)
    begin
        p_dysx_reg <= PROD_W'(dir_y_reg * sx_reg);
        p_dxsy_reg <= PROD_W'(dir_x_reg * sy_reg);
        p_pxsy_reg <= PROD_W'(plane_x_reg * sy_reg);
        p_pysx_reg <= PROD_W'(plane_y_reg * sx_reg);
        p_pxdy_reg <= DPROD_W'(plane_x_reg * dir_y_reg);
        p_dxpy_reg <= DPROD_W'(dir_x_reg * plane_y_reg);
    end

    // stage 3: transformed coordinates and determinant
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic signed [DET_W-1:0] det_reg;

    always_ff @(posedge clk)
    begin
        nx_reg  <= NUM_W'(p_dysx_reg) - NUM_W'(p_dxsy_reg);
        ny_reg  <= NUM_W'(p_pxsy_reg) - NUM_W'(p_pysx_reg);
        det_reg <= DET_W'(p_pxdy_reg) - DET_W'(p_dxpy_reg);
    end

    // stage 4: depth dividend and divisor magnitudes, centre sum
    logic [NUM_W-1:0]        ny_mag4_reg;
    logic [DET_W-1:0]        det_mag4_reg;
    logic                    s1_4_reg, ny_neg4_reg, det_nz4_reg;
    logic signed [SUM_W-1:0] sum4_reg;

    always_ff @(posedge clk)
    begin
        ny_mag4_reg  <= ny_reg[NUM_W-1] ? (~ny_reg + 1'b1) : ny_reg;
        det_mag4_reg <= det_reg[DET_W-1] ? (~det_reg + 1'b1) : det_reg;
        s1_4_reg     <= ny_reg[NUM_W-1] ^ det_reg[DET_W-1];
        ny_neg4_reg  <= ny_reg[NUM_W-1];
        det_nz4_reg  <= (det_reg != '0);
        sum4_reg     <= SUM_W'(ny_reg) + SUM_W'(nx_reg);
    end

    // stage 5: centre sum magnitude and sign
    logic [NUM_W-1:0] ny_mag5_reg;
    logic [DET_W-1:0] det_mag5_reg;
    logic             s1_5_reg, s2_5_reg, det_nz5_reg;
    logic [SUM_W-1:0] sum_mag5_reg;

    always_ff @(posedge clk)
    begin
        ny_mag5_reg  <= ny_mag4_reg;
        det_mag5_reg <= det_mag4_reg;
        s1_5_reg     <= s1_4_reg;
        det_nz5_reg  <= det_nz4_reg;
        s2_5_reg     <= sum4_reg[SUM_W-1] ^ ny_neg4_reg;
        sum_mag5_reg <= sum4_reg[SUM_W-1] ? (~sum4_reg + 1'b1) : sum4_reg;
    end

    // stage 6: half width times centre sum, divider operands
    logic [DIV1_NW-1:0] n1_reg, n2_reg;
    logic [DIV1_DW-1:0] d1_reg;
    logic [DIV2_DW-1:0] d2_reg;
    logic               s1_6_reg, s2_6_reg, det_nz6_reg;

    always_ff @(posedge clk)
    begin
        n1_reg      <= {ny_mag5_reg, 16'd0};
        d1_reg      <= det_mag5_reg;
        n2_reg      <= DIV1_NW'(CPROD_W'(scr_w_reg[SCR_W-1:1] * sum_mag5_reg));
        d2_reg      <= ny_mag5_reg;
        s1_6_reg    <= s1_5_reg;
        s2_6_reg    <= s2_5_reg;
        det_nz6_reg <= det_nz5_reg;
    end

    // depth and centre dividers run side by side
    logic [DIV1_NW-1:0] q1, q2;

    ssp_div #(.NW(DIV1_NW), .DW(DIV1_DW)) u_div_depth (
        .clk (clk),
        .num (n1_reg),
        .den (d1_reg),
        .quo (q1)
    );

    ssp_div #(.NW(DIV1_NW), .DW(DIV2_DW)) u_div_center (
        .clk (clk),
        .num (n2_reg),
        .den (d2_reg),
        .quo (q2)
    );

    // side data alongside the first dividers
    logic va_reg [DIV1_NW];
    logic la_reg [DIV1_NW];
    logic s1a_reg [DIV1_NW];
    logic s2a_reg [DIV1_NW];
    logic dnza_reg [DIV1_NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV1_NW; i++)
            begin
                va_reg[i] <= 1'b0;
            end
        end
        else
        begin
            va_reg[0] <= v_reg[6];
            for (int i = 1; i < DIV1_NW; i++)
            begin
                va_reg[i] <= va_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg[0]   <= l_reg[6];
        s1a_reg[0]  <= s1_6_reg;
        s2a_reg[0]  <= s2_6_reg;
        dnza_reg[0] <= det_nz6_reg;
        for (int i = 1; i < DIV1_NW; i++)
        begin
            la_reg[i]   <= la_reg[i-1];
            s1a_reg[i]  <= s1a_reg[i-1];
            s2a_reg[i]  <= s2a_reg[i-1];
            dnza_reg[i] <= dnza_reg[i-1];
        end
    end

    // stage 7: signed saturation of depth and centre
    logic               v7_reg, l7_reg, det_nz7_reg;
    logic signed [31:0] depth7_reg;
    logic signed [20:0] center7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= va_reg[DIV1_NW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        l7_reg      <= la_reg[DIV1_NW-1];
        det_nz7_reg <= dnza_reg[DIV1_NW-1];
        if (s1a_reg[DIV1_NW-1])
        begin
            depth7_reg <= (q1 > DIV1_NW'(64'd2147483648)) ? 32'sh80000000
                                                           : 32'(~q1 + 1'b1);
        end
        else
        begin
            depth7_reg <= (q1 > DIV1_NW'(64'd2147483647)) ? 32'sh7fffffff : 32'(q1);
        end
        if (s2a_reg[DIV1_NW-1])
        begin
            center7_reg <= (q2 > DIV1_NW'(64'd1048576)) ? 21'sh100000
                                                         : 21'(~q2 + 1'b1);
        end
        else
        begin
            center7_reg <= (q2 > DIV1_NW'(64'd1048575)) ? 21'sh0fffff : 21'(q2);
        end
    end

    // stage 8: degenerate flag and size divider operands
    logic               v8_reg, l8_reg, degen8_reg;
    logic signed [31:0] depth8_reg;
    logic signed [20:0] center8_reg;
    logic [DIV3_NW-1:0] n3_reg;
    logic [DIV3_DW-1:0] d3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
        end
        else
        begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        l8_reg      <= l7_reg;
        degen8_reg  <= ~det_nz7_reg | (depth7_reg == '0);
        depth8_reg  <= depth7_reg;
        center8_reg <= center7_reg;
        n3_reg      <= {scr_h_reg, 16'd0};
        d3_reg      <= depth7_reg[31] ? (~depth7_reg + 1'b1) : depth7_reg;
    end

    logic [DIV3_NW-1:0] q3;

    ssp_div #(.NW(DIV3_NW), .DW(DIV3_DW)) u_div_size (
        .clk (clk),
        .num (n3_reg),
        .den (d3_reg),
        .quo (q3)
    );

    // side data alongside the size divider
    logic               vb_reg [DIV3_NW];
    logic               lb_reg [DIV3_NW];
    logic               dgb_reg [DIV3_NW];
    logic signed [31:0] dpb_reg [DIV3_NW];
    logic signed [20:0] ctb_reg [DIV3_NW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV3_NW; i++)
            begin
                vb_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vb_reg[0] <= v8_reg;
            for (int i = 1; i < DIV3_NW; i++)
            begin
                vb_reg[i] <= vb_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lb_reg[0]  <= l8_reg;
        dgb_reg[0] <= degen8_reg;
        dpb_reg[0] <= depth8_reg;
        ctb_reg[0] <= center8_reg;
        for (int i = 1; i < DIV3_NW; i++)
        begin
            lb_reg[i]  <= lb_reg[i-1];
            dgb_reg[i] <= dgb_reg[i-1];
            dpb_reg[i] <= dpb_reg[i-1];
            ctb_reg[i] <= ctb_reg[i-1];
        end
    end

    // stage 9: size saturation
    logic               v9_reg, l9_reg, degen9_reg;
    logic signed [31:0] depth9_reg;
    logic signed [20:0] center9_reg;
    logic [15:0]        size9_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v9_reg <= 1'b0;
        end
        else
        begin
            v9_reg <= vb_reg[DIV3_NW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        l9_reg      <= lb_reg[DIV3_NW-1];
        degen9_reg  <= dgb_reg[DIV3_NW-1];
        depth9_reg  <= dpb_reg[DIV3_NW-1];
        center9_reg <= ctb_reg[DIV3_NW-1];
        size9_reg   <= (q3 > DIV3_NW'(65535)) ? 16'hffff : q3[15:0];
    end

    // stage 10: drawing rectangle clamps
    logic [15:0]        half_sz;
    logic [11:0]        half_h;
    logic signed [17:0] sr_s;
    logic [17:0]        er_u, h_ext, hm1;
    logic signed [22:0] sc_s, ec_s, w_ext, wm1;
    logic [11:0]        sr_c, er_c;
    logic [19:0]        sc_c;
    logic [20:0]        ec_c;

    always_comb
    begin
        half_sz = {1'b0, size9_reg[15:1]};
        half_h  = scr_h_reg[SCR_W-1:1];
        sr_s    = $signed({6'd0, half_h}) - $signed({2'd0, half_sz});
        er_u    = {6'd0, half_h} + {2'd0, half_sz};
        h_ext   = {5'd0, scr_h_reg};
        hm1     = h_ext - 18'd1;
        sc_s    = 23'(center9_reg) - $signed({7'd0, half_sz});
        ec_s    = 23'(center9_reg) + $signed({7'd0, half_sz});
        w_ext   = $signed({10'd0, scr_w_reg});
        wm1     = w_ext - 23'sd1;
        sr_c    = sr_s[17] ? 12'd0 : sr_s[11:0];
        er_c    = (er_u >= h_ext) ? hm1[11:0] : er_u[11:0];
        sc_c    = sc_s[22] ? 20'd0 : sc_s[19:0];
        ec_c    = (ec_s >= w_ext) ? wm1[20:0] : ec_s[20:0];
    end

    logic               done_reg, last_reg, degen_reg;
    logic signed [31:0] depth_reg;
    logic signed [20:0] center_reg, ec_reg;
    logic [15:0]        size_reg;
    logic [19:0]        sc_reg;
    logic [11:0]        sr_reg, er_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= v9_reg;
        end
    end

    // degenerate results read as zero
    always_ff @(posedge clk)
    begin
        last_reg   <= l9_reg;
        degen_reg  <= degen9_reg;
        depth_reg  <= degen9_reg ? '0 : depth9_reg;
        center_reg <= degen9_reg ? '0 : center9_reg;
        size_reg   <= degen9_reg ? '0 : size9_reg;
        sc_reg     <= degen9_reg ? '0 : sc_c;
        ec_reg     <= degen9_reg ? '0 : $signed(ec_c);
        sr_reg     <= degen9_reg ? '0 : sr_c;
        er_reg     <= degen9_reg ? '0 : er_c;
    end

    assign done          = done_reg;
    assign depth         = depth_reg;
    assign center_column = center_reg;
    assign sprite_size   = size_reg;
    assign start_column  = sc_reg;
    assign end_column    = ec_reg;
    assign start_row     = sr_reg;
    assign end_row       = er_reg;
    assign degenerate    = degen_reg;
    assign last_out      = last_reg;

    // every transfer in gives one done strobe, after the delay set by LATENCY
    `ASSERT_DELAY(a_latency, clk, rst_n, start, LATENCY, done)
    // degenerate results carry no geometry
    `ASSERT_IMPLIES(a_degen_zero, clk, rst_n, done && degenerate,
        depth == 0 && sprite_size == 0 && start_row == 0 && end_row == 0)
    // a degenerate depth flag follows a zero saturated depth
    `ASSERT_IMPLIES(a_depth_nz, clk, rst_n, done && !degenerate, depth != 0)

endmodule

[hw/rtl/ssp_div.sv]
// pipelined restoring divider on magnitudes, one quotient bit per stage
module ssp_div
    import ssp_pkg::*;
#(
    parameter int NW = DIV1_NW,
    parameter int DW = DIV1_DW
) (
    input  logic          clk,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] den_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++)
        begin : g_stage
            logic [DW-1:0] rem_in;
            logic [NW-1:0] num_in;
            logic [NW-1:0] quo_in;
            logic [DW-1:0] den_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;
            logic [DW-1:0] rem_next;
            logic [NW-1:0] num_next;
            logic [NW-1:0] quo_next;

            // stage source: ports for the first stage, previous stage otherwise
            if (k == 0)
            begin : g_first
                assign rem_in = '0;
                assign num_in = num;
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign num_in = num_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            // shift in one numerator bit, subtract if it fits
            always_comb
            begin
                trial    = {rem_in, num_in[NW-1]};
                diff     = trial - {1'b0, den_in};
                ge       = (trial >= {1'b0, den_in});
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                num_next = {num_in[NW-2:0], 1'b0};
                quo_next = {quo_in[NW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= den_in;
            end
        end
    endgenerate

    assign quo = quo_reg[NW-1];

endmodule
